### sv/wmp_pkg.sv
// Shared types, constants and helpers for the wave mip pyramid writer.
// No dependencies; imported by every module of the block.
package wmp_pkg;

  localparam int WAVE_SAMPLES   = 128;
  localparam int SLOTS_PER_PART = 64;
  localparam int WAVE_WORDS     = 256;
  localparam int LEVELS         = 6;

  localparam int CNT_W  = 7;
  localparam int SIZE_W = CNT_W + 1;
  localparam int IDX_W  = 8;
  localparam int VAL_W  = 8;
  localparam int PART_W = 3;
  localparam int SLOT_W = 6;
  localparam int ADDR_W = 18;
  localparam int WORD_W = 24;

  localparam logic [ADDR_W-1:0] MEM_BASE = 18'h20000;
  localparam logic [IDX_W-1:0]  IDX_ROOT = 8'd254;
  localparam logic [IDX_W-1:0]  IDX_PAD  = 8'd255;

  // handoff from one level to the next
  typedef struct packed {
    logic                    go;
    logic                    store;
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        pos;
    logic                    last;
  } wmp_hand_t;

  // one memory write offered to the output stage
  typedef struct packed {
    logic                    active;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic                    run_end;
    logic                    done;
  } wmp_wr_t;

  typedef enum logic [1:0] {
    TAIL_IDLE,
    TAIL_ROOT,
    TAIL_PAD
  } wmp_tail_t;

  // first index of pyramid level lvl
  function automatic int wmp_level_offset(input int lvl);
    int sum;
    sum = 0;
    for (int j = 0; j < LEVELS; j++) begin
      if (j < lvl) sum += WAVE_SAMPLES >> j;
    end
    return sum;
  endfunction

endpackage

### sv/wmp_cell.sv
// One pyramid level: holds the waiting first element of a pair and, when the
// second arrives, writes their average and hands it up. Uses wmp_pkg.
module wmp_cell #(
  parameter int LEVEL = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  wmp_pkg::wmp_hand_t hand_in,
  output wmp_pkg::wmp_hand_t hand_out,
  output wmp_pkg::wmp_wr_t   wr,
  output logic              tail_req
);
  import wmp_pkg::*;

  localparam int   SIZE      = WAVE_SAMPLES >> LEVEL;
  localparam int   NEXT_SIZE = SIZE >> 1;
  localparam int   OFFSET    = wmp_level_offset(LEVEL + 1);
  localparam logic NEXT_OK   = (LEVEL + 1 < LEVELS) && ((NEXT_SIZE >> 1) >= 2);

  logic signed [VAL_W-1:0] pending;
  logic                    tok_valid;
  logic signed [VAL_W-1:0] tok_value;
  logic [CNT_W-1:0]        tok_pos;
  logic                    tok_last;

  logic signed [VAL_W:0]   pair_sum;
  logic signed [VAL_W-1:0] avg;
  logic [CNT_W-1:0]        pos_up;
  logic                    fwd_ok;
  logic                    climb;

  // arithmetic floor of the pair mean
  assign pair_sum = {pending[VAL_W-1], pending} + {tok_value[VAL_W-1], tok_value};
  assign avg      = pair_sum[VAL_W:1];
  assign pos_up   = tok_pos >> 1;
  assign fwd_ok   = NEXT_OK && ({1'b0, pos_up} < SIZE_W'(NEXT_SIZE));
  assign climb    = fwd_ok && pos_up[0];

  assign hand_out.go    = tok_valid && advance && climb;
  assign hand_out.store = tok_valid && advance && fwd_ok && !pos_up[0];
  assign hand_out.value = avg;
  assign hand_out.pos   = pos_up;
  assign hand_out.last  = tok_last;

  assign wr.active  = tok_valid;
  assign wr.index   = IDX_W'(OFFSET) + IDX_W'(pos_up);
  assign wr.value   = avg;
  assign wr.run_end = !climb && !tok_last;
  assign wr.done    = 1'b0;

  assign tail_req = tok_valid && advance && tok_last && !climb;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
      pending   <= '0;
    end else begin
      if (hand_in.go) begin
        tok_valid <= 1'b1;
      end else if (advance) begin
        tok_valid <= 1'b0;
      end
      if (hand_in.store) begin
        pending <= hand_in.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hand_in.go) begin
      tok_value <= hand_in.value;
      tok_pos   <= hand_in.pos;
      tok_last  <= hand_in.last;
    end
  end

endmodule

### sv/wmp_tail.sv
// End of wave sequencer: writes the zero root and the zero pad word.
// Uses wmp_pkg.
module wmp_tail (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            advance,
  output wmp_pkg::wmp_wr_t wr
);
  import wmp_pkg::*;

  wmp_tail_t state;
  wmp_tail_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      TAIL_IDLE: if (start) state_next = TAIL_ROOT;
      TAIL_ROOT: if (advance) state_next = TAIL_PAD;
      TAIL_PAD:  if (advance) state_next = TAIL_IDLE;
      default:   state_next = TAIL_IDLE;
    endcase
  end

  always_comb begin
    wr = '0;
    unique case (state)
      TAIL_IDLE: wr.active = 1'b0;
      TAIL_ROOT: begin
        wr.active = 1'b1;
        wr.index  = IDX_ROOT;
      end
      TAIL_PAD: begin
        wr.active  = 1'b1;
        wr.index   = IDX_PAD;
        wr.run_end = 1'b1;
        wr.done    = 1'b1;
      end
      default: wr.active = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TAIL_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/wave_mip_pyramid_writer.sv
// Top level of the wave mip pyramid writer: sample intake, row of level
// cells, end of wave sequencer and the output word register. Uses wmp_pkg.
//
// Input channel (in_valid/in_ready): one signed sample per word, 128 to a
// wave; part and wave_slot are latched with the first sample of a wave.
// Output channel (out_valid/out_ready): one memory write per word, address
// 0x20000 + part*16384 + slot*256 + index, data = sample << 16.
// A sample causes 1 to 9 writes: its raw value, one average for each level
// it completes, and after the last sample of a wave the zero words at
// indices 254 and 255. The raw write enters the output register in the cycle
// after acceptance; the level cells and then the tail offer the rest in order.
// The single output register moves one word per cycle unless out_ready holds
// it, and a sample occupies the block until its last write has entered that
// register; writes average exactly 2 per sample over a wave (256 writes per
// 128 samples). The next sample is taken only after the previous sample's last
// write has entered the output register. Reset clears the sample count, the
// waiting pair values and all tokens. While out_valid is high and out_ready is
// low, the output word holds and the block stops in place; no word is dropped.
module wave_mip_pyramid_writer (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [wmp_pkg::VAL_W-1:0]         sample,
  input  logic        [wmp_pkg::PART_W-1:0]        part,
  input  logic        [wmp_pkg::SLOT_W-1:0]        wave_slot,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic        [wmp_pkg::ADDR_W-1:0]        mem_address,
  output logic signed [wmp_pkg::WORD_W-1:0]        mem_word,
  output logic                                     run_end,
  output logic                                     wave_done
);
  import wmp_pkg::*;

  localparam logic LVL0_OK = (WAVE_SAMPLES >> 1) >= 2;

  logic [CNT_W-1:0]  sample_count;
  logic [ADDR_W-1:0] wave_base;
  logic [ADDR_W-1:0] base_calc;
  logic [ADDR_W-1:0] base_now;
  logic              out_load;
  logic              accept;
  logic              busy;
  logic              is_last;
  logic              first;
  logic              fwd0;
  logic              climb0;
  logic              entry_tail;

  wmp_hand_t          hand [LEVELS];
  wmp_hand_t          hand_end;
  wmp_wr_t            cell_wr [LEVELS];
  logic [LEVELS-1:0]  cell_active;
  logic [LEVELS-1:0]  cell_tail;
  wmp_wr_t            raw_wr;
  wmp_wr_t            tail_wr;
  wmp_wr_t            src;

  assign out_load = !out_valid || out_ready;
  assign busy     = (|cell_active) || tail_wr.active;
  assign in_ready = out_load && !busy;
  assign accept   = in_valid && in_ready;

  assign is_last = sample_count >= CNT_W'(WAVE_SAMPLES - 1);
  assign first   = sample_count == '0;
  assign fwd0    = LVL0_OK && ({1'b0, sample_count} < SIZE_W'(WAVE_SAMPLES));
  assign climb0  = fwd0 && sample_count[0];

  assign base_calc = MEM_BASE
                   + ADDR_W'(part) * ADDR_W'(SLOTS_PER_PART * WAVE_WORDS)
                   + (ADDR_W'(wave_slot) << IDX_W);
  assign base_now  = (accept && first) ? base_calc : wave_base;

  assign hand[0].go    = accept && climb0;
  assign hand[0].store = accept && fwd0 && !sample_count[0];
  assign hand[0].value = sample;
  assign hand[0].pos   = sample_count;
  assign hand[0].last  = is_last;

  assign raw_wr.active  = accept;
  assign raw_wr.index   = IDX_W'(sample_count);
  assign raw_wr.value   = sample;
  assign raw_wr.run_end = !climb0 && !is_last;
  assign raw_wr.done    = 1'b0;

  assign entry_tail = accept && is_last && !climb0;

  for (genvar k = 0; k < LEVELS; k++) begin : g_level
    wmp_hand_t up;

    wmp_cell #(
      .LEVEL (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (out_load),
      .hand_in  (hand[k]),
      .hand_out (up),
      .wr       (cell_wr[k]),
      .tail_req (cell_tail[k])
    );

    assign cell_active[k] = cell_wr[k].active;

    if (k + 1 < LEVELS) begin : g_link
      assign hand[k+1] = up;
    end else begin : g_top
      assign hand_end = up;
    end
  end

  wmp_tail u_tail (
    .clk     (clk),
    .rst     (rst),
    .start   (entry_tail || (|cell_tail)),
    .advance (out_load),
    .wr      (tail_wr)
  );

  // at most one source is live in any cycle
  always_comb begin
    src = '0;
    if (accept) src = raw_wr;
    for (int k = 0; k < LEVELS; k++) begin
      if (cell_wr[k].active) src = cell_wr[k];
    end
    if (tail_wr.active) src = tail_wr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      wave_base    <= MEM_BASE;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        sample_count <= is_last ? '0 : sample_count + 1'b1;
        if (first) wave_base <= base_calc;
      end
      if (out_load) out_valid <= src.active;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mem_address <= base_now + ADDR_W'(src.index);
      mem_word    <= {src.value, {(WORD_W - VAL_W){1'b0}}};
      run_end     <= src.run_end;
      wave_done   <= src.done;
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cell_active, tail_wr.active}))
    else $error("more than one write source active");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !hand_end.go && !hand_end.store)
    else $error("handoff beyond the top level");

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && wave_done |-> run_end)
    else $error("wave end word without run end");

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && is_last |=> sample_count == '0)
    else $error("sample count not cleared at wave end");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for wave_mip_pyramid_writer. One wave of samples and 32 more go
// in; each memory write is checked against a local pyramid predictor. Needs wmp_pkg.
module tb;
  import wmp_pkg::*;

  localparam int HALF_PERIOD    = 2;
  localparam int RESET_CYCLES   = 7;
  localparam int WAVES          = 1;
  localparam int TAIL_ITEMS     = 32;
  localparam int CORNER_ITEMS   = 24;
  localparam int MAX_GAP        = 14;
  localparam int STALL_AT_WRITE = 100;
  localparam int STALL_CYCLES   = 150;
  localparam int DRAIN_CYCLES   = 20;
  localparam int IDLE_LIMIT     = 1000;
  localparam int MAX_WRITES     = 9;

  typedef struct packed {
    logic signed [VAL_W-1:0] smp;
    logic [PART_W-1:0]       prt;
    logic [SLOT_W-1:0]       slt;
  } wave_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0]        addr;
    logic signed [WORD_W-1:0] data;
    logic                     last_of_sample;
    logic                     end_of_wave;
  } mip_write_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic signed [VAL_W-1:0]   sample    = '0;
  logic [PART_W-1:0]         part      = '0;
  logic [SLOT_W-1:0]         wave_slot = '0;
  logic                      out_ready = 1'b0;
  logic                      in_ready;
  logic                      out_valid;
  logic [ADDR_W-1:0]         mem_address;
  logic signed [WORD_W-1:0]  mem_word;
  logic                      run_end;
  logic                      wave_done;

  wave_word_t sample_backlog[$];
  mip_write_t mip_writes_due[$];

  // predictor state
  logic [CNT_W-1:0]        wave_pos = '0;
  logic signed [VAL_W-1:0] half_pair [LEVELS];
  logic [PART_W-1:0]       wave_part = '0;
  logic [SLOT_W-1:0]       wave_slot_held = '0;

  logic signed [VAL_W-1:0] corner_samples [CORNER_ITEMS];

  int fault_count = 0;
  int words_sent  = 0;
  int writes_seen = 0;
  int tx_gap      = 0;
  int rx_hold     = 0;
  int idle_cycles = 0;

  wave_mip_pyramid_writer DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .part        (part),
    .wave_slot   (wave_slot),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mem_address (mem_address),
    .mem_word    (mem_word),
    .run_end     (run_end),
    .wave_done   (wave_done)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic mip_write_t mip_write(input logic [IDX_W-1:0] idx,
                                           input logic signed [VAL_W-1:0] v,
                                           input logic fin);
    logic [31:0] full;
    mip_write_t  w;
    full = MEM_BASE + wave_part * SLOTS_PER_PART * WAVE_WORDS
         + wave_slot_held * WAVE_WORDS + idx;
    w.addr           = full[ADDR_W-1:0];
    w.data           = {v, {(WORD_W-VAL_W){1'b0}}};
    w.last_of_sample = 1'b0;
    w.end_of_wave    = fin;
    return w;
  endfunction

  // Writes caused by one sample: raw value, then each completed pair average
  // up the levels, then the root and pad zeros at the end of a wave.
  function automatic void predict_mip_writes(input wave_word_t wd);
    mip_write_t              batch [MAX_WRITES];
    logic signed [VAL_W-1:0] v;
    logic signed [VAL_W:0]   pair_sum;
    int                      pos;
    int                      size;
    int                      offset;
    int                      idx;
    int                      n;
    logic                    wave_end;
    v        = wd.smp;
    pos      = wave_pos;
    size     = WAVE_SAMPLES;
    offset   = 0;
    n        = 0;
    wave_end = (pos >= WAVE_SAMPLES - 1);
    if (pos == 0) begin
      wave_part      = wd.prt;
      wave_slot_held = wd.slt;
    end
    batch[n] = mip_write(pos[IDX_W-1:0], v, 1'b0);
    n++;
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      if ((size >> 1) < 2 || pos >= size) break;
      if (pos % 2 == 0) begin
        half_pair[lvl] = v;
        break;
      end
      pair_sum = half_pair[lvl] + v;
      v        = pair_sum[VAL_W:1];  // drop lsb of 9-bit sum: floor halving
      offset  += size;
      pos      = pos >> 1;
      size     = size >> 1;
      idx      = offset + pos;
      batch[n] = mip_write(idx[IDX_W-1:0], v, 1'b0);
      n++;
    end
    if (wave_end) begin
      batch[n] = mip_write(IDX_ROOT, '0, 1'b0);
      n++;
      batch[n] = mip_write(IDX_PAD, '0, 1'b1);
      n++;
      wave_pos = '0;
    end else begin
      wave_pos = wave_pos + 1'b1;
    end
    batch[n-1].last_of_sample = 1'b1;
    for (int i = 0; i < n; i++) mip_writes_due.push_back(batch[i]);
  endfunction

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    fault_count++;
    $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
  endtask

  // sample side: gap drawn per word, no gap in every third block of 24
  always @(posedge clk) begin : drive_samples
    wave_word_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_mip_writes({sample, part, wave_slot});
      if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap   <= tx_gap - 1;
      end else if (sample_backlog.size() > 0) begin
        nxt       = sample_backlog.pop_front();
        sample    <= nxt.smp;
        part      <= nxt.prt;
        wave_slot <= nxt.slt;
        in_valid  <= 1'b1;
        tx_gap    <= (((words_sent / 24) % 3) == 1) ? 0 : $urandom_range(0, MAX_GAP);
        words_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // write side: check each word, then hold ready low for a drawn count
  always @(posedge clk) begin : check_writes
    mip_write_t due;
    int         hold;
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
    end else begin
      hold = rx_hold;
      if (out_valid && out_ready) begin
        if (mip_writes_due.size() == 0) begin
          fault_count++;
          $display("%0t: write expected none, got address %0h data %0h",
                   $time, mem_address, mem_word);
        end else begin
          due = mip_writes_due.pop_front();
          if (mem_address !== due.addr) report_field("mem_address", due.addr, mem_address);
          if (mem_word !== due.data) report_field("mem_word", due.data, mem_word);
          if (run_end !== due.last_of_sample)
            report_field("run_end", due.last_of_sample, run_end);
          if (wave_done !== due.end_of_wave)
            report_field("wave_done", due.end_of_wave, wave_done);
        end
        writes_seen++;
        // one long hold-off lets the block back up into the sample side
        if (writes_seen == STALL_AT_WRITE) hold = STALL_CYCLES;
        else if (((writes_seen / 50) % 3) == 2) hold = 0;
        else hold = $urandom_range(0, MAX_GAP);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        rx_hold   <= hold - 1;
      end else begin
        out_ready <= 1'b1;
        rx_hold   <= 0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    wave_word_t w;
    for (int i = 0; i < LEVELS; i++) half_pair[i] = '0;
    // full-scale runs first so extremes reach the upper levels, then
    // mixed-sign pairs in both orders and the rounding of odd sums
    corner_samples = '{127, 127, 127, 127, 127, 127, 127, 127,
                       -128, -128, -128, -128, -128, -128, -128, -128,
                       127, -128, -128, 127, -1, 0, 0, -1};
    for (int k = 0; k < CORNER_ITEMS; k++) begin
      w.smp = corner_samples[k];
      w.prt = (k == 0) ? 3'd7 : PART_W'($urandom_range(0, 7));
      w.slt = (k == 0) ? 6'd63 : SLOT_W'($urandom_range(0, 63));
      sample_backlog.push_back(w);
    end
    for (int k = CORNER_ITEMS; k < WAVES * WAVE_SAMPLES + TAIL_ITEMS; k++) begin
      if ($urandom_range(0, 7) == 0) w.smp = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
      else w.smp = VAL_W'($urandom_range(0, 255));
      w.prt = PART_W'($urandom_range(0, 7));
      w.slt = SLOT_W'($urandom_range(0, 63));
      if (k == WAVE_SAMPLES) begin
        w.prt = '0;
        w.slt = '0;
      end
      sample_backlog.push_back(w);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (sample_backlog.size() != 0 || in_valid) @(posedge clk);
    while (mip_writes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0 && mip_writes_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
